/* design/ofhw_pkg.sv */
// shared types and constants for the overwriting fifo with high-water count
// no dependencies

package ofhw_pkg;

  localparam int CNT_W = 5;
  localparam int CFG_ADDR_W = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_CAP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_CAP     = 2'd1;

  typedef struct packed {
    logic shift;
    logic load;
  } ofhw_cell_ctl_t;

endpackage

/* design/overwriting_fifo_with_high_water_core.sv */
// top level of the overwriting fifo with high-water capacity count
// builds a chain of ofhw_cell instances, oldest word in cell 0; uses ofhw_pkg
//
// usage:
//   in_*  : one item per handshake, in_tuser is the opcode (enqueue or dequeue),
//           in_tdata carries the word to enqueue.
//   out_* : one result item per input item: removed word, head word, fill level
//           and capacity count.
//   cfg_* : write-only register port, used while the block is idle; in_tready is low during a write.
// an item is accepted and processed in the same cycle; its result sits in the output
// register on the next cycle, so throughput is one item per cycle while out_tready
// stays high and cfg_we stays low. the path per cycle is the count compare
// and the one-step shift of the cell chain.
// when the receiver stalls the result is held and in_tready drops until it is
// taken; a result taken in the same cycle lets the next item in.
// reset clears fill level and capacity count and sets the maximum to 16;
// cell contents are not cleared, words are only read once written.
// enqueue on a full queue shifts out the oldest word and keeps the fill level.

module overwriting_fifo_with_high_water_core
  import ofhw_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] data_in
  input  logic [((WORD_BITS+7)/8)*8-1:0] in_tdata,
  // [0] opcode
  input  logic                   in_tuser,

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // data_out, head_word, fill_level, capacity_count, zero pad
  output logic [((2*WORD_BITS+2*CNT_W+7)/8)*8-1:0] out_tdata,
  // [0] data_valid, [1] head_valid
  output logic [1:0]             out_tuser,

  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  localparam int OUT_TDATA_W = ((2*WORD_BITS+2*CNT_W+7)/8)*8;
  localparam int DEPTH_CLAMP = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH_CLAMP);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] grown_r, grown_nxt;
  logic [CNT_W-1:0] max_cap_r, max_cap_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] dout_r, dout_nxt;
  logic                 dvalid_r, dvalid_nxt;
  logic [WORD_BITS-1:0] head_r, head_nxt;
  logic                 hvalid_r, hvalid_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]     cap_r, cap_nxt;

  logic [CNT_W-1:0] emax;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] load_idx;
  logic [CNT_W-1:0] cfg_lim;
  logic             acc, is_enq, full, shift_all, load_en;

  logic [WORD_BITS-1:0] cell_q   [DEPTH];
  logic [WORD_BITS-1:0] cell_nxt [DEPTH];

  assign in_tready = (!out_valid_r || out_tready) && !cfg_we;
  assign acc       = in_tvalid && in_tready;
  assign is_enq    = (in_tuser == OP_ENQ);

  always_comb begin
    emax = max_cap_r;
    if (emax == '0) begin
      emax = CNT_W'(1);
    end
    if (emax > DEPTH_CNT) begin
      emax = DEPTH_CNT;
    end
  end

  assign full      = (count_r >= emax);
  assign count_inc = count_r + CNT_W'(1);
  assign load_en   = acc && is_enq;
  assign load_idx  = full ? (count_r - CNT_W'(1)) : count_r;
  assign shift_all = acc && (is_enq ? full : (count_r != '0));
  assign cfg_lim   = (cfg_wdata > emax) ? emax : cfg_wdata;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ofhw_cell_ctl_t       ctl;
    logic [WORD_BITS-1:0] nbr;

    assign ctl.shift = shift_all;
    assign ctl.load  = load_en && (int'(load_idx) == i);

    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    ofhw_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .next_word(nbr),
      .new_word (in_tdata[WORD_BITS-1:0]),
      .word_q   (cell_q[i]),
      .word_nxt (cell_nxt[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    grown_nxt     = grown_r;
    max_cap_nxt   = max_cap_r;
    out_valid_nxt = out_valid_r && !out_tready;
    dout_nxt      = dout_r;
    dvalid_nxt    = dvalid_r;
    head_nxt      = head_r;
    hvalid_nxt    = hvalid_r;
    fill_nxt      = fill_r;
    cap_nxt       = cap_r;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_INITIAL_CAP: grown_nxt = (cfg_lim < count_r) ? count_r : cfg_lim;
        CFG_MAX_CAP:     max_cap_nxt = cfg_wdata;
        default:         ;
      endcase
    end else if (acc) begin
      dout_nxt   = '0;
      dvalid_nxt = 1'b0;
      if (is_enq) begin
        if (!full) begin
          count_nxt = count_inc;
          if (grown_r < count_inc) begin
            grown_nxt = count_inc;
          end
        end
      end else if (count_r != '0) begin
        count_nxt  = count_r - CNT_W'(1);
        dout_nxt   = cell_q[0];
        dvalid_nxt = 1'b1;
      end
      out_valid_nxt = 1'b1;
      hvalid_nxt    = (count_nxt != '0);
      head_nxt      = (count_nxt != '0) ? cell_nxt[0] : '0;
      fill_nxt      = count_nxt;
      cap_nxt       = grown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      grown_r     <= '0;
      max_cap_r   <= CNT_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      grown_r     <= grown_nxt;
      max_cap_r   <= max_cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dout_r   <= dout_nxt;
    dvalid_r <= dvalid_nxt;
    head_r   <= head_nxt;
    hvalid_r <= hvalid_nxt;
    fill_r   <= fill_nxt;
    cap_r    <= cap_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({cap_r, fill_r, head_r, dout_r});
  assign out_tuser  = {hvalid_r, dvalid_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("fill level beyond cell count");

  a_grown_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
    grown_r >= count_r)
    else $error("capacity count below fill level");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_we) |=> out_valid_r)
    else $error("accepted item gave no result");

  a_deq_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_we && !is_enq && count_r != '0) |=>
      (dvalid_r && fill_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue of a held word not reported");

  a_enq_head: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_we && is_enq) |=> (hvalid_r && fill_r != '0))
    else $error("enqueue left the queue empty");

endmodule

/* design/ofhw_cell.sv */
// one storage cell of the fifo chain: takes its neighbor's word on a shift
// or a new word on a load; uses ofhw_pkg

module ofhw_cell
  import ofhw_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  ofhw_cell_ctl_t       ctl,
  input  logic [WORD_BITS-1:0] next_word,
  input  logic [WORD_BITS-1:0] new_word,
  output logic [WORD_BITS-1:0] word_q,
  output logic [WORD_BITS-1:0] word_nxt
);

  logic [WORD_BITS-1:0] word_r;

  always_comb begin
    word_nxt = word_r;
    if (ctl.load) begin
      word_nxt = new_word;
    end else if (ctl.shift) begin
      word_nxt = next_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

/* tb/overwriting_fifo_with_high_water_core_test.sv */
// self-checking testbench for overwriting_fifo_with_high_water_core: streams enqueue and
// dequeue items under random idling and checks every result item against a predictor
// depends on ofhw_pkg and the core rtl only

module overwriting_fifo_with_high_water_core_test;
  import ofhw_pkg::*;

  localparam int DEPTH = 16;
  localparam int WORD_BITS = 32;
  localparam int IN_W = ((WORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * WORD_BITS + 2 * CNT_W + 7) / 8) * 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HI = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic [WORD_BITS-1:0] data_out;
    logic                 data_valid;
    logic [WORD_BITS-1:0] head_word;
    logic                 head_valid;
    logic [CNT_W-1:0]     fill_level;
    logic [CNT_W-1:0]     capacity_count;
  } fifo_result_t;

  class fifo_scoreboard;
    logic [WORD_BITS-1:0] words[$];
    int unsigned          high_water;
    logic [CNT_W-1:0]     max_reg;
    fifo_result_t         due[$];
    int unsigned          mismatches;

    function new();
      high_water = 0;
      max_reg = 5'd16;
      mismatches = 0;
    endfunction

    function int unsigned usable_size();
      int unsigned m;
      m = max_reg;
      if (m < 1) m = 1;
      if (m > DEPTH) m = DEPTH;
      return m;
    endfunction

    function void apply_reg(logic [CFG_ADDR_W-1:0] addr, logic [CNT_W-1:0] value);
      int unsigned v;
      v = value;
      if (addr == CFG_INITIAL_CAP) begin
        if (v > usable_size()) v = usable_size();
        if (v < words.size()) v = words.size();
        high_water = v;
      end else if (addr == CFG_MAX_CAP) begin
        max_reg = value;
      end
    endfunction

    function void note_item(logic op, logic [WORD_BITS-1:0] word);
      fifo_result_t r;
      r = '{default: '0};
      if (op == OP_ENQ) begin
        if (words.size() >= usable_size()) begin
          void'(words.pop_front());
          words.push_back(word);
        end else begin
          words.push_back(word);
          if (high_water < words.size()) high_water = words.size();
        end
      end else if (words.size() > 0) begin
        r.data_out = words.pop_front();
        r.data_valid = 1'b1;
      end
      if (words.size() > 0) begin
        r.head_word = words[0];
        r.head_valid = 1'b1;
      end
      r.fill_level = CNT_W'(words.size());
      r.capacity_count = CNT_W'(high_water);
      due.push_back(r);
    endfunction

    task report(string what);
      $display("error at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [OUT_W-1:0] tdata, logic [1:0] tuser);
      fifo_result_t want;
      logic [WORD_BITS-1:0] got_data, got_head;
      logic [CNT_W-1:0] got_fill, got_cap;
      if (due.size() == 0) begin
        report("result item with no item pending");
        return;
      end
      want = due.pop_front();
      got_data = tdata[0 +: WORD_BITS];
      got_head = tdata[WORD_BITS +: WORD_BITS];
      got_fill = tdata[2 * WORD_BITS +: CNT_W];
      got_cap = tdata[2 * WORD_BITS + CNT_W +: CNT_W];
      if (got_data !== want.data_out)
        report($sformatf("data_out %h, want %h", got_data, want.data_out));
      if (tuser[0] !== want.data_valid)
        report($sformatf("data_valid %b, want %b", tuser[0], want.data_valid));
      if (got_head !== want.head_word)
        report($sformatf("head_word %h, want %h", got_head, want.head_word));
      if (tuser[1] !== want.head_valid)
        report($sformatf("head_valid %b, want %b", tuser[1], want.head_valid));
      if (got_fill !== want.fill_level)
        report($sformatf("fill_level %0d, want %0d", got_fill, want.fill_level));
      if (got_cap !== want.capacity_count)
        report($sformatf("capacity_count %0d, want %0d", got_cap, want.capacity_count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CNT_W-1:0] cfg_wdata;

  fifo_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int idle_modes[4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{38, 38}};
  logic [CNT_W-1:0] init_vals[PHASES] = '{5'd0, 5'd31, 5'd2, 5'd16, 5'd5, 5'd3, 5'd0, 5'd12};
  logic [CNT_W-1:0] max_vals[PHASES] = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0, 5'd17, 5'd8, 5'd12};

  overwriting_fifo_with_high_water_core #(
    .DEPTH(DEPTH),
    .WORD_BITS(WORD_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else if (in_tvalid || sb.due.size() != 0) begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_item(input logic op, input logic [WORD_BITS-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_W'(word);
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, word);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.apply_reg(addr, value);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    int n, burst, enq_pct;
    logic op;
    logic [WORD_BITS-1:0] word;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_ENQ;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_INITIAL_CAP;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: empty dequeues, extreme words
    send_idle_pct = 38;
    recv_stall_pct = 38;
    send_item(OP_DEQ, $urandom);
    send_item(OP_ENQ, 32'h0000_0000);
    send_item(OP_ENQ, 32'hFFFF_FFFF);
    send_item(OP_DEQ, $urandom);
    send_item(OP_DEQ, $urandom);
    send_item(OP_DEQ, $urandom);
    settle();

    // zero maximum acts as one, initial above maximum is limited
    write_reg(CFG_MAX_CAP, 5'd0);
    write_reg(CFG_INITIAL_CAP, 5'd31);
    cfg_we <= 1'b0;
    send_item(OP_ENQ, 32'h1234_5678);
    send_item(OP_ENQ, 32'h8765_4321);
    send_item(OP_DEQ, $urandom);
    send_item(OP_DEQ, $urandom);
    settle();

    // overwrite of the oldest word when full
    write_reg(CFG_MAX_CAP, 5'd3);
    write_reg(CFG_INITIAL_CAP, 5'd0);
    cfg_we <= 1'b0;
    send_item(OP_ENQ, 32'hA5A5_A5A5);
    send_item(OP_ENQ, 32'h5A5A_5A5A);
    send_item(OP_ENQ, 32'h0F0F_0F0F);
    send_item(OP_ENQ, 32'hF0F0_F0F0);
    settle();

    // maximum lowered below the fill level, unused register indexes
    write_reg(CFG_MAX_CAP, 5'd1);
    write_reg(CFG_UNUSED_LO, 5'd31);
    write_reg(CFG_UNUSED_HI, 5'd0);
    cfg_we <= 1'b0;
    send_item(OP_ENQ, 32'hDEAD_BEEF);
    send_item(OP_DEQ, $urandom);
    settle();

    // initial value raised to the fill level
    write_reg(CFG_INITIAL_CAP, 5'd0);
    cfg_we <= 1'b0;
    send_item(OP_ENQ, 32'h8000_0001);
    send_item(OP_DEQ, $urandom);
    send_item(OP_DEQ, $urandom);
    send_item(OP_DEQ, $urandom);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p % 2 == 1) begin
        write_reg(CFG_INITIAL_CAP, init_vals[p]);
        write_reg(CFG_MAX_CAP, max_vals[p]);
      end else begin
        write_reg(CFG_MAX_CAP, max_vals[p]);
        write_reg(CFG_INITIAL_CAP, init_vals[p]);
      end
      write_reg((p % 2 == 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, CNT_W'($urandom_range(31)));
      cfg_we <= 1'b0;
      send_idle_pct = idle_modes[p % 4][0];
      recv_stall_pct = idle_modes[p % 4][1];
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst = $urandom_range(40, 4);
        case ($urandom_range(3))
          0: enq_pct = 85;
          1: enq_pct = 15;
          2: enq_pct = 50;
          default: enq_pct = 100;
        endcase
        for (int b = 0; b < burst && n < PHASE_ITEMS; b++) begin
          op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
          case ($urandom_range(9))
            0: word = '0;
            1: word = '1;
            default: word = $urandom;
          endcase
          send_item(op, word);
          n++;
        end
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ofhw_pkg.sv
design/ofhw_cell.sv
design/overwriting_fifo_with_high_water_core.sv
tb/overwriting_fifo_with_high_water_core_test.sv
